@@ rtl/core/hdc_pkg.sv @@
package hdc_pkg;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_TOPBIT = 16'h8000;

    localparam logic [1:0]  ST_GOOD  = 2'd0;
    localparam logic [1:0]  ST_SHORT = 2'd1;
    localparam logic [1:0]  ST_BAD   = 2'd2;

    localparam logic [1:0]  HELD_NONE = 2'd0;
    localparam logic [1:0]  HELD_ONE  = 2'd1;
    localparam logic [1:0]  HELD_FULL = 2'd2;

    // One classified request handed from the front to the back.
    typedef struct packed {
        logic       is_data;
        logic [7:0] data;
        logic       last;
    } hdc_entry_t;

    // CRC-16, MSB first, one byte folded in over eight bit steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOPBIT) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/hdc_front.sv @@
module hdc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              q_ready,
    output logic              q_push,
    output hdc_pkg::hdc_entry_t q_entry
);
    import hdc_pkg::*;

    logic esc_armed_reg;
    logic esc_armed_next;
    logic accept;
    logic is_flag;
    logic is_esc;
    logic is_data;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign is_flag  = (s_tdata == FLAG_BYTE);
    assign is_esc   = (s_tdata == ESC_BYTE);
    assign is_data  = !is_flag && !is_esc;

    // Flags and escapes that do not end a burst leave nothing for the back end.
    assign q_push          = accept && (is_data || s_tlast);
    assign q_entry.is_data = is_data;
    assign q_entry.data    = esc_armed_reg ? (s_tdata ^ ESC_XOR) : s_tdata;
    assign q_entry.last    = s_tlast;

    always_comb begin
        esc_armed_next = esc_armed_reg;
        if (accept) begin
            if (s_tlast) begin
                esc_armed_next = 1'b0;
            end else if (is_esc) begin
                esc_armed_next = 1'b1;
            end else if (is_data) begin
                esc_armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_armed_reg <= 1'b0;
        end else begin
            esc_armed_reg <= esc_armed_next;
        end
    end

endmodule

@@ rtl/core/hdc_queue.sv @@
module hdc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hdc_pkg::hdc_entry_t push_entry,
    output logic                not_full,
    input  logic                pop,
    output logic                head_valid,
    output hdc_pkg::hdc_entry_t head_entry
);
    import hdc_pkg::*;

    hdc_entry_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign not_full   = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/hdc_back.sv @@
module hdc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  hdc_pkg::hdc_entry_t head_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);
    import hdc_pkg::*;

    logic [7:0]  hb0_reg, hb1_reg;
    logic [7:0]  hb0_next, hb1_next;
    logic [1:0]  held_reg, held_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_emit_reg;
    logic [7:0]  out_byte_reg;
    logic        out_done_reg;
    logic [1:0]  out_status_reg;
    logic        emit;
    logic        produce;
    logic [1:0]  status;
    logic [1:0]  held_work;
    logic [15:0] crc_work;

    assign pop     = head_valid && (!out_valid_reg || m_tready);
    assign emit    = head_entry.is_data && (held_reg == HELD_FULL);
    assign produce = emit || head_entry.last;

    always_comb begin
        hb0_next  = hb0_reg;
        hb1_next  = hb1_reg;
        held_work = held_reg;
        crc_work  = crc_reg;
        status    = ST_GOOD;
        if (head_entry.is_data) begin
            unique case (held_reg)
                HELD_NONE: begin
                    hb0_next  = head_entry.data;
                    held_work = HELD_ONE;
                end
                HELD_ONE: begin
                    hb1_next  = head_entry.data;
                    held_work = HELD_FULL;
                end
                default: begin
                    crc_work = crc_byte(crc_reg, hb0_reg);
                    hb0_next = hb1_reg;
                    hb1_next = head_entry.data;
                end
            endcase
        end
        held_next = held_work;
        crc_next  = crc_work;
        if (head_entry.last) begin
            if (held_work != HELD_FULL) begin
                status = ST_SHORT;
            end else if ({hb0_next, hb1_next} == crc_work) begin
                status = ST_GOOD;
            end else begin
                status = ST_BAD;
            end
            held_next = HELD_NONE;
            crc_next  = CRC_INIT;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (pop && produce) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            hb0_reg <= hb0_next;
            hb1_reg <= hb1_next;
        end
        if (pop && produce) begin
            out_emit_reg   <= emit;
            out_byte_reg   <= emit ? hb0_reg : 8'h00;
            out_done_reg   <= head_entry.last;
            out_status_reg <= status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= HELD_NONE;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                held_reg <= held_next;
                crc_reg  <= crc_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_byte_reg, out_emit_reg};
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_status_reg;

endmodule

@@ rtl/core/hdlc_deframe_crc_check.sv @@
// HDLC deframer with CRC-16 check.
// Input stream: one received line byte per request in s_tdata, s_tlast set
// on the final byte of a burst. Flag bytes are dropped, escapes undone.
// Output stream: a request whenever a payload byte leaves the two-byte
// holdback, when a burst ends, or both. m_tdata[0] marks a valid payload
// byte in m_tdata[8:1]; m_tlast marks the end of the burst and m_tuser then
// carries the status (0 good, 1 fewer than two bytes, 2 CRC mismatch).
// Payload bytes are provisional until that status arrives.
// Path from input acceptance to the result on m_tvalid:
// the front end classifies and unstuffs into a two-entry queue, the back
// end updates holdback and CRC (eight-step unrolled update) into the output
// register. Throughput is one byte per cycle while m_tready is high.
// Reset clears escape, holdback count, CRC and both queue and output state;
// s_tready is high in the first cycle after reset.
// When m_tready is low the output register holds, the queue fills, and
// s_tready drops once both queue entries are taken.
module hdlc_deframe_crc_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // raw_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // byte_valid, payload_byte, zero fill
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // frame_status
);
    import hdc_pkg::*;

    hdc_entry_t push_entry;
    hdc_entry_t head_entry;
    logic       push;
    logic       not_full;
    logic       pop;
    logic       head_valid;

    hdc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (not_full),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    hdc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (not_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    hdc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // A status other than good only comes with the end of a burst.
    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser == ST_GOOD))
        else $error("frame status set without burst end");

    // Every output request carries a byte or a burst end.
    a_no_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || m_tlast))
        else $error("empty output request");

    // Without a valid byte the payload field is zero.
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'h00))
        else $error("payload set without byte_valid");

    // The queue is empty right after reset, so input is ready.
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule
